>>> rtl/core/esg_pkg.sv
package esg_pkg;

    // field widths
    localparam int RADIUS_BITS = 10;
    localparam int COORD_BITS  = 12;
    localparam int SPAN_BITS   = COORD_BITS + 1;

    // datapath widths: squares, odd-step increments, sums of two squared products
    localparam int SQ_BITS   = 2 * RADIUS_BITS;
    localparam int STEP_BITS = 3 * RADIUS_BITS + 1;
    localparam int PROD_BITS = 4 * RADIUS_BITS;
    localparam int SUM_BITS  = 4 * RADIUS_BITS + 1;

    // input operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    // products formed one per cycle on the shared multiplier after a start
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_RX2,
        MUL_RY2,
        MUL_LIM,
        MUL_HALF,
        MUL_DSTEP
    } mul_op_t;

    // which span the output register loads
    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_CENTER,
        EMIT_UPPER,
        EMIT_LOWER
    } emit_sel_t;

    typedef struct packed {
        logic      load;
        mul_op_t   mul_op;
        logic      advance;
        logic      walk;
        emit_sel_t emit;
    } dp_cmd_t;

    typedef struct packed {
        logic walk_more;
        logic last_row;
        logic flat;
    } dp_status_t;

endpackage

>>> rtl/core/esg_datapath.sv
module esg_datapath
    import esg_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dp_cmd_t                       cmd,
    output dp_status_t                    status,
    input  logic signed [COORD_BITS-1:0]  center_x,
    input  logic signed [COORD_BITS-1:0]  center_y,
    input  logic        [RADIUS_BITS-1:0] radius_x,
    input  logic        [RADIUS_BITS-1:0] radius_y,
    output logic signed [SPAN_BITS-1:0]   span_left,
    output logic signed [SPAN_BITS-1:0]   span_right,
    output logic signed [SPAN_BITS-1:0]   span_row,
    output logic                          last_of_step,
    output logic                          shape_done
);

    // held shape
    logic signed [COORD_BITS-1:0]  cx_reg;
    logic signed [COORD_BITS-1:0]  cy_reg;
    logic        [RADIUS_BITS-1:0] rx_reg;
    logic        [RADIUS_BITS-1:0] ry_reg;

    // incremental ellipse terms
    logic [SQ_BITS-1:0]     rx2_reg;
    logic [SQ_BITS-1:0]     ry2_reg;
    logic [SUM_BITS-1:0]    limit_reg;
    logic [SUM_BITS-1:0]    q_reg;
    logic [STEP_BITS-1:0]   e_reg;
    logic [STEP_BITS-1:0]   d_reg;
    logic [RADIUS_BITS-1:0] x_reg;
    logic [RADIUS_BITS-1:0] row_reg;

    // output register
    logic [SPAN_BITS-1:0] left_reg;
    logic [SPAN_BITS-1:0] right_reg;
    logic [SPAN_BITS-1:0] row_out_reg;
    logic                 last_reg;
    logic                 done_reg;

    logic [SQ_BITS-1:0]     mul_a;
    logic [SQ_BITS-1:0]     mul_b;
    logic [PROD_BITS-1:0]   prod;
    logic [RADIUS_BITS:0]   rx_odd;
    logic [SPAN_BITS-1:0]   cx_ext;
    logic [SPAN_BITS-1:0]   cy_ext;
    logic [SPAN_BITS-1:0]   x_ext;
    logic [SPAN_BITS-1:0]   y_ext;
    logic [SPAN_BITS-1:0]   row_sel;
    logic                   last_sel;
    logic                   done_sel;

    // 2*rx - 1, the odd factor of the first column step
    assign rx_odd = {rx_reg, 1'b0} - (RADIUS_BITS + 1)'(1);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = rx2_reg;
        mul_b = ry2_reg;
        unique case (cmd.mul_op)
            MUL_RX2:
            begin
                mul_a = SQ_BITS'(rx_reg);
                mul_b = SQ_BITS'(rx_reg);
            end
            MUL_RY2:
            begin
                mul_a = SQ_BITS'(ry_reg);
                mul_b = SQ_BITS'(ry_reg);
            end
            MUL_LIM:
            begin
                mul_a = rx2_reg;
                mul_b = ry2_reg;
            end
            MUL_HALF:
            begin
                mul_a = rx2_reg;
                mul_b = SQ_BITS'(ry_reg);
            end
            MUL_DSTEP:
            begin
                mul_a = ry2_reg;
                mul_b = SQ_BITS'(rx_odd);
            end
            default:
            begin
                mul_a = rx2_reg;
                mul_b = ry2_reg;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // shape capture, setup products, row advance and column walk
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg <= center_x;
            cy_reg <= center_y;
            rx_reg <= radius_x;
            ry_reg <= radius_y;
        end
        unique case (cmd.mul_op)
            MUL_RX2:
            begin
                rx2_reg <= prod[SQ_BITS-1:0];
            end
            MUL_RY2:
            begin
                ry2_reg <= prod[SQ_BITS-1:0];
            end
            MUL_LIM:
            begin
                limit_reg <= SUM_BITS'(prod);
                q_reg     <= SUM_BITS'(prod);
            end
            MUL_HALF:
            begin
                d_reg <= STEP_BITS'(prod);
            end
            MUL_DSTEP:
            begin
                limit_reg <= limit_reg + SUM_BITS'(d_reg >> 1);
                d_reg     <= STEP_BITS'(prod);
                e_reg     <= STEP_BITS'(rx2_reg);
                x_reg     <= rx_reg;
                row_reg   <= '0;
            end
            default:
            begin
            end
        endcase
        // next row: add rx2*(2y+1)
        if (cmd.advance)
        begin
            q_reg   <= q_reg + SUM_BITS'(e_reg);
            e_reg   <= e_reg + STEP_BITS'({rx2_reg, 1'b0});
            row_reg <= row_reg + RADIUS_BITS'(1);
        end
        // one column in: subtract ry2*(2x-1)
        if (cmd.walk)
        begin
            q_reg <= q_reg - SUM_BITS'(d_reg);
            d_reg <= d_reg - STEP_BITS'({ry2_reg, 1'b0});
            x_reg <= x_reg - RADIUS_BITS'(1);
        end
    end

    assign status.walk_more = (x_reg != '0) && (q_reg > limit_reg);
    assign status.last_row  = (row_reg >= ry_reg);
    assign status.flat      = (ry_reg == '0);

    // span coordinates, wrapped to the span width
    assign cx_ext = SPAN_BITS'(cx_reg);
    assign cy_ext = SPAN_BITS'(cy_reg);
    assign x_ext  = SPAN_BITS'(x_reg);
    assign y_ext  = SPAN_BITS'(row_reg);

    always_comb
    begin
        row_sel  = cy_ext;
        last_sel = 1'b1;
        done_sel = 1'b0;
        unique case (cmd.emit)
            EMIT_NONE:
            begin
                row_sel  = cy_ext;
                last_sel = 1'b1;
                done_sel = 1'b0;
            end
            EMIT_CENTER:
            begin
                row_sel  = cy_ext;
                last_sel = 1'b1;
                done_sel = status.flat;
            end
            EMIT_UPPER:
            begin
                row_sel  = cy_ext + y_ext;
                last_sel = 1'b0;
                done_sel = 1'b0;
            end
            EMIT_LOWER:
            begin
                row_sel  = cy_ext - y_ext;
                last_sel = 1'b1;
                done_sel = status.last_row;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.emit != EMIT_NONE)
        begin
            left_reg    <= cx_ext - x_ext;
            right_reg   <= cx_ext + x_ext;
            row_out_reg <= row_sel;
            last_reg    <= last_sel;
            done_reg    <= done_sel;
        end
    end

    assign span_left    = left_reg;
    assign span_right   = right_reg;
    assign span_row     = row_out_reg;
    assign last_of_step = last_reg;
    assign shape_done   = done_reg;

`ifndef SYNTHESIS
    // a column step never runs past the center column
    a_walk_inside: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk |-> (x_reg != '0))
        else $error("column walk with zero half width");

    // a row leaves the walk with its corner inside the limit
    a_upper_inside: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.emit == EMIT_UPPER) && (x_reg != '0)) |-> (q_reg <= limit_reg))
        else $error("span emitted outside the ellipse limit");

    // each walk step takes exactly one column
    a_walk_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk |=> (x_reg == $past(x_reg) - RADIUS_BITS'(1)))
        else $error("half width step lost");
`endif

endmodule

>>> rtl/core/esg_ctrl.sv
module esg_ctrl
    import esg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       operation,
    output logic       out_valid,
    input  logic       out_stall,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RX2,
        S_RY2,
        S_LIM,
        S_HALF,
        S_DSTEP,
        S_CENTER,
        S_ADVANCE,
        S_WALK,
        S_UPPER,
        S_LOWER
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   active_reg;
    logic   active_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    logic accept;
    logic out_free;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        cmd.load       = 1'b0;
        cmd.mul_op     = MUL_NONE;
        cmd.advance    = 1'b0;
        cmd.walk       = 1'b0;
        cmd.emit       = EMIT_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_START)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_RX2;
                    end
                    else if (active_reg)
                    begin
                        state_next = S_ADVANCE;
                    end
                end
            end
            S_RX2:
            begin
                cmd.mul_op = MUL_RX2;
                state_next = S_RY2;
            end
            S_RY2:
            begin
                cmd.mul_op = MUL_RY2;
                state_next = S_LIM;
            end
            S_LIM:
            begin
                cmd.mul_op = MUL_LIM;
                state_next = S_HALF;
            end
            S_HALF:
            begin
                cmd.mul_op = MUL_HALF;
                state_next = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.mul_op = MUL_DSTEP;
                state_next = S_CENTER;
            end
            S_CENTER:
            begin
                if (out_free)
                begin
                    cmd.emit    = EMIT_CENTER;
                    active_next = !status.flat;
                    state_next  = S_IDLE;
                end
            end
            S_ADVANCE:
            begin
                cmd.advance = 1'b1;
                state_next  = S_WALK;
            end
            S_WALK:
            begin
                if (status.walk_more)
                begin
                    cmd.walk = 1'b1;
                end
                else
                begin
                    state_next = S_UPPER;
                end
            end
            S_UPPER:
            begin
                if (out_free)
                begin
                    cmd.emit   = EMIT_UPPER;
                    state_next = S_LOWER;
                end
            end
            S_LOWER:
            begin
                if (out_free)
                begin
                    cmd.emit    = EMIT_LOWER;
                    active_next = !status.last_row;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid: set on a load, cleared once the span is taken
    always_comb
    begin
        if (cmd.emit != EMIT_NONE)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // a span is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit != EMIT_NONE) |-> (!out_valid_reg || !out_stall))
        else $error("span register overwritten while stalled");

    // next with no shape gives nothing
    a_idle_next: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (operation != OP_START) && !active_reg) |=> (state_reg == S_IDLE))
        else $error("next row taken with no active shape");

    // the final row ends the shape
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.emit == EMIT_LOWER) && status.last_row) |=> !active_reg)
        else $error("shape still active after its last row");
`endif

endmodule

>>> rtl/core/ellipse_span_generator.sv
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  operation, center_x, center_y, radius_x, radius_y
// out      output     out_valid/out_stall  span_left, span_right, span_row, last_of_step,
//                                          shape_done
//
// one item is worked at a time; a start runs its setup states, then loads the center span
// (a shared multiplier forms the five setup products, one per cycle)
// a next row advances the row, walks the half width in one column per step, then loads both spans
// (one add, compare and subtract step of the column walk per cycle)
// asynchronous active-low reset clears the controller: no shape, no span pending
// a stalled output holds its span; the controller waits in its emit state until it is free
module ellipse_span_generator
    import esg_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic signed [COORD_BITS-1:0]  center_x,
    input  logic signed [COORD_BITS-1:0]  center_y,
    input  logic        [RADIUS_BITS-1:0] radius_x,
    input  logic        [RADIUS_BITS-1:0] radius_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SPAN_BITS-1:0]   span_left,
    output logic signed [SPAN_BITS-1:0]   span_right,
    output logic signed [SPAN_BITS-1:0]   span_row,
    output logic                          last_of_step,
    output logic                          shape_done
);

    dp_cmd_t    cmd;
    dp_status_t status;

    esg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    esg_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius_x     (radius_x),
        .radius_y     (radius_y),
        .span_left    (span_left),
        .span_right   (span_right),
        .span_row     (span_row),
        .last_of_step (last_of_step),
        .shape_done   (shape_done)
    );

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb
    import esg_pkg::*;
();

    localparam int   ITEM_TARGET  = 1050;
    localparam int   QUIET_ITEMS  = 150;
    localparam int   MAX_ROWS     = 40;
    localparam int   DRAIN_CYCLES = 40;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic signed [SPAN_BITS-1:0] left;
        logic signed [SPAN_BITS-1:0] right;
        logic signed [SPAN_BITS-1:0] row;
        logic                        last;
        logic                        done;
    } span_t;

    typedef struct packed {
        logic                          op;
        logic signed [COORD_BITS-1:0]  cx;
        logic signed [COORD_BITS-1:0]  cy;
        logic        [RADIUS_BITS-1:0] rx;
        logic        [RADIUS_BITS-1:0] ry;
        bit                            typed;
        int                            typed_count;
        span_t                         typed_span;
    } directed_row_t;

    // dut ports
    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic                          operation = OP_START;
    logic signed [COORD_BITS-1:0]  center_x = '0;
    logic signed [COORD_BITS-1:0]  center_y = '0;
    logic        [RADIUS_BITS-1:0] radius_x = '0;
    logic        [RADIUS_BITS-1:0] radius_y = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [SPAN_BITS-1:0]   span_left;
    logic signed [SPAN_BITS-1:0]   span_right;
    logic signed [SPAN_BITS-1:0]   span_row;
    logic                          last_of_step;
    logic                          shape_done;

    // shape state mirrored from the block
    bit                            shape_active = 1'b0;
    logic signed [COORD_BITS-1:0]  held_cx = '0;
    logic signed [COORD_BITS-1:0]  held_cy = '0;
    logic        [RADIUS_BITS-1:0] held_rx = '0;
    logic        [RADIUS_BITS-1:0] held_ry = '0;
    logic        [RADIUS_BITS-1:0] row_offset = '0;
    logic        [RADIUS_BITS-1:0] half_width = '0;
    u64_t                          outer_limit = '0;

    span_t         pending_spans[$];
    directed_row_t directed_rows[$];
    int            mismatches = 0;
    int            items_sent = 0;
    bit            idle_enable = 1'b1;
    int            stall_left = 0;

    ellipse_span_generator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius_x     (radius_x),
        .radius_y     (radius_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .span_left    (span_left),
        .span_right   (span_right),
        .span_row     (span_row),
        .last_of_step (last_of_step),
        .shape_done   (shape_done)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // shrink the half width until the point lies on or inside the outer limit
    function automatic void walk_half_width(input u64_t y);
        u64_t rx2;
        u64_t ry2;
        u64_t hw;
        rx2 = u64_t'(held_rx) * u64_t'(held_rx);
        ry2 = u64_t'(held_ry) * u64_t'(held_ry);
        hw  = u64_t'(half_width);
        while (hw > 0 && rx2 * y * y + ry2 * hw * hw > outer_limit)
            hw--;
        half_width = RADIUS_BITS'(hw);
    endfunction

    function automatic span_t make_span(input longint row, input bit last, input bit done);
        span_t  s;
        longint c;
        c = longint'(held_cx);
        s.left  = SPAN_BITS'(c - longint'(half_width));
        s.right = SPAN_BITS'(c + longint'(half_width));
        s.row   = SPAN_BITS'(row);
        s.last  = last;
        s.done  = done;
        return s;
    endfunction

    // spans caused by one input transfer
    task automatic compute_spans(
        input  logic                          op,
        input  logic signed [COORD_BITS-1:0]  cx,
        input  logic signed [COORD_BITS-1:0]  cy,
        input  logic        [RADIUS_BITS-1:0] rx,
        input  logic        [RADIUS_BITS-1:0] ry,
        output int                            count,
        output span_t                         first,
        output span_t                         second
    );
        u64_t rx2;
        u64_t y;
        bit   done;
        count  = 0;
        first  = '0;
        second = '0;
        if (op == OP_START)
        begin
            held_cx = cx;
            held_cy = cy;
            held_rx = rx;
            held_ry = ry;
            rx2 = u64_t'(rx) * u64_t'(rx);
            outer_limit = rx2 * u64_t'(ry) * u64_t'(ry) + ((rx2 * u64_t'(ry)) >> 1);
            half_width = rx;
            row_offset = '0;
            walk_half_width(0);
            done = (ry == 0);
            shape_active = !done;
            first = make_span(longint'(held_cy), 1'b1, done);
            count = 1;
        end
        else if (shape_active)
        begin
            y = u64_t'(row_offset) + 1;
            row_offset = RADIUS_BITS'(y);
            walk_half_width(y);
            done = (y >= u64_t'(held_ry));
            if (done)
                shape_active = 1'b0;
            first  = make_span(longint'(held_cy) + longint'(y), 1'b0, 1'b0);
            second = make_span(longint'(held_cy) - longint'(y), 1'b1, done);
            count = 2;
        end
    endtask

    // drive one transfer, then queue what it should produce
    task automatic issue(
        input logic                          op,
        input logic signed [COORD_BITS-1:0]  cx,
        input logic signed [COORD_BITS-1:0]  cy,
        input logic        [RADIUS_BITS-1:0] rx,
        input logic        [RADIUS_BITS-1:0] ry,
        input bit                            typed,
        input int                            typed_count,
        input span_t                         typed_span
    );
        int    count;
        span_t first;
        span_t second;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        center_x  <= cx;
        center_y  <= cy;
        radius_x  <= rx;
        radius_y  <= ry;
        do
            @(posedge clk);
        while (in_stall);
        compute_spans(op, cx, cy, rx, ry, count, first, second);
        if (typed)
        begin
            if (typed_count > 0)
                pending_spans.push_back(typed_span);
        end
        else
        begin
            if (count > 0)
                pending_spans.push_back(first);
            if (count > 1)
                pending_spans.push_back(second);
        end
        if (count > 0)
            items_sent++;
    endtask

    task automatic add_row(
        input logic op, input int cx, input int cy, input int rx, input int ry,
        input bit typed, input int n, input int l, input int r, input int rw,
        input bit last, input bit done
    );
        directed_row_t d;
        d.op                = op;
        d.cx                = COORD_BITS'(cx);
        d.cy                = COORD_BITS'(cy);
        d.rx                = RADIUS_BITS'(rx);
        d.ry                = RADIUS_BITS'(ry);
        d.typed             = typed;
        d.typed_count       = n;
        d.typed_span.left   = SPAN_BITS'(l);
        d.typed_span.right  = SPAN_BITS'(r);
        d.typed_span.row    = SPAN_BITS'(rw);
        d.typed_span.last   = last;
        d.typed_span.done   = done;
        directed_rows.push_back(d);
    endtask

    // receiver stalls in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (idle_enable && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 15);
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // compare each output transfer with the oldest pending span
    always @(posedge clk)
    begin : check_spans
        span_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_spans.size() == 0)
            begin
                report_mismatch("span with nothing pending, row", longint'(span_row), 0);
            end
            else
            begin
                want = pending_spans.pop_front();
                if (span_left !== want.left)
                    report_mismatch("span_left", longint'(span_left), longint'(want.left));
                if (span_right !== want.right)
                    report_mismatch("span_right", longint'(span_right), longint'(want.right));
                if (span_row !== want.row)
                    report_mismatch("span_row", longint'(span_row), longint'(want.row));
                if (last_of_step !== want.last)
                    report_mismatch("last_of_step", longint'(last_of_step), longint'(want.last));
                if (shape_done !== want.done)
                    report_mismatch("shape_done", longint'(shape_done), longint'(want.done));
            end
        end
    end

    initial
    begin : stimulus
        int                    k;
        int                    i;
        int                    pick;
        int                    rows;
        bit                    quiet;
        logic [RADIUS_BITS-1:0] rx;
        logic [RADIUS_BITS-1:0] ry;

        // next while idle, zero radii, extreme centers and radii, abandoned shapes
        add_row(OP_NEXT,   1234,  -777,   99,  512, 1, 0,     0,     0,     0, 0, 0);
        add_row(OP_START,     0,     0,    0,    0, 1, 1,     0,     0,     0, 1, 1);
        add_row(OP_NEXT,   -100,   300, 1023, 1023, 1, 0,     0,     0,     0, 0, 0);
        add_row(OP_START,  2047,  2047, 1023,    0, 1, 1,  1024,  3070,  2047, 1, 1);
        add_row(OP_START, -2048, -2048, 1023,    0, 1, 1, -3071, -1025, -2048, 1, 1);
        add_row(OP_START,   100,   -50,    0,    3, 1, 1,   100,   100,   -50, 1, 0);
        add_row(OP_NEXT,  -2048,  2047, 1023, 1023, 0, 0,     0,     0,     0, 0, 0);
        add_row(OP_NEXT,   2047, -2048,    0,    0, 0, 0,     0,     0,     0, 0, 0);
        add_row(OP_NEXT,     17,    33,  555,  222, 0, 0,     0,     0,     0, 0, 0);
        add_row(OP_NEXT,      0,     0,    0,    0, 1, 0,     0,     0,     0, 0, 0);
        add_row(OP_START, -2048,  2047, 1023, 1023, 1, 1, -3071, -1025,  2047, 1, 0);
        add_row(OP_NEXT,      1,     2,    3,    4, 0, 0,     0,     0,     0, 0, 0);
        add_row(OP_NEXT,   -513,   511,  768,  256, 0, 0,     0,     0,     0, 0, 0);
        add_row(OP_NEXT,   2047,  2047, 1023, 1023, 0, 0,     0,     0,     0, 0, 0);
        add_row(OP_START,     5,     5, 1023,    1, 1, 1, -1018,  1028,     5, 1, 0);
        add_row(OP_NEXT,      0,     0,    0,    0, 0, 0,     0,     0,     0, 0, 0);
        add_row(OP_START,     0,     0,    1, 1023, 1, 1,    -1,     1,     0, 1, 0);
        add_row(OP_NEXT,    -99,    99,   11,   22, 0, 0,     0,     0,     0, 0, 0);
        add_row(OP_NEXT,     42,   -42,   33,   44, 0, 0,     0,     0,     0, 0, 0);
        add_row(OP_START,    10,   -10,    3,    2, 0, 0,     0,     0,     0, 0, 0);
        add_row(OP_NEXT,      0,     0,    0,    0, 0, 0,     0,     0,     0, 0, 0);
        add_row(OP_NEXT,      0,     0,    0,    0, 0, 0,     0,     0,     0, 0, 0);
        add_row(OP_NEXT,    700,  -700,  100,  100, 1, 0,     0,     0,     0, 0, 0);
        add_row(OP_START,  2047, -2048,    0, 1023, 1, 1,  2047,  2047, -2048, 1, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        for (k = 0; k < directed_rows.size(); k++)
            issue(directed_rows[k].op, directed_rows[k].cx, directed_rows[k].cy,
                  directed_rows[k].rx, directed_rows[k].ry, directed_rows[k].typed,
                  directed_rows[k].typed_count, directed_rows[k].typed_span);

        // random shapes: mostly whole ellipses, some cut short, some stray next items
        while (items_sent < ITEM_TARGET)
        begin
            quiet = (items_sent >= ITEM_TARGET - QUIET_ITEMS);
            if (quiet)
                idle_enable <= 1'b0;
            else if ($urandom_range(0, 29) == 0)
                idle_enable <= !idle_enable;
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                issue(OP_NEXT, COORD_BITS'($urandom), COORD_BITS'($urandom),
                      RADIUS_BITS'($urandom), RADIUS_BITS'($urandom), 1'b0, 0, '0);
            end
            else
            begin
                rx = ($urandom_range(0, 9) == 0) ? RADIUS_BITS'($urandom_range(0, 1023))
                                                 : RADIUS_BITS'($urandom_range(0, 31));
                ry = ($urandom_range(0, 9) == 0) ? RADIUS_BITS'($urandom_range(0, 1023))
                                                 : RADIUS_BITS'($urandom_range(0, 12));
                issue(OP_START, COORD_BITS'($urandom), COORD_BITS'($urandom), rx, ry,
                      1'b0, 0, '0);
                rows = int'(ry);
                // cut the shape short, and keep tall ones to a few dozen rows
                if (pick < 25 || rows > MAX_ROWS)
                    rows = $urandom_range(0, (rows > MAX_ROWS) ? MAX_ROWS : rows);
                for (i = 0; i < rows; i++)
                    issue(OP_NEXT, COORD_BITS'($urandom), COORD_BITS'($urandom),
                          RADIUS_BITS'($urandom), RADIUS_BITS'($urandom), 1'b0, 0, '0);
                if ($urandom_range(0, 4) == 0)
                    issue(OP_NEXT, COORD_BITS'($urandom), COORD_BITS'($urandom),
                          RADIUS_BITS'($urandom), RADIUS_BITS'($urandom), 1'b0, 0, '0);
            end
        end
        in_valid <= 1'b0;

        // drain outstanding spans, then watch for strays
        while (pending_spans.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
